>>> hdl/hvd_pkg.sv
// haversine distance package: widths, cordic arctangent table, shared constants
// no dependencies; imported by every module of the haversine distance core
package hvd_pkg;

  localparam int unsigned CordicSteps = 30;
  localparam int unsigned QBits       = 30;
  localparam int unsigned SqrtSteps   = 31;
  localparam logic [31:0] CordicInvGain = 32'd652032874;
  localparam logic [31:0] DegToRadQ36   = 32'd1199381129;
  localparam logic [32:0] DistMax       = 33'h1_FFFF_FFFF;

  // cordic datapath width, signed
  localparam int unsigned CW = 34;

  typedef logic signed [CW-1:0] cval_t;

  // arctangent of 2^-i in q30
  function automatic cval_t atan_lut(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
      18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
      21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
      24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
      27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
      default: v = 32'h0;
    endcase
    return cval_t'(v);
  endfunction

endpackage

>>> hdl/hvd_sin.sv
// pipelined sine of a half-angle in units of 2^-(f+1) degree, q30 result
// quadrant reduction, radian scaling and a 30-stage rotation cordic; uses hvd_pkg
module hvd_sin import hvd_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = 22,
  parameter int unsigned UW = ANGLE_FRAC_BITS + 11
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [UW-1:0] u_i,
  output cval_t                sin_o
);

  localparam int unsigned LAT = CordicSteps + 3;
  localparam logic [UW-1:0] Quarter = UW'(90) << (ANGLE_FRAC_BITS + 1);
  localparam int unsigned RW = ANGLE_FRAC_BITS + 8;
  localparam logic [63:0] RoundK = 64'd1 << (ANGLE_FRAC_BITS + 6);

  // stage 0: magnitude, quadrant and remainder by compare-subtract
  logic [UW-1:0] mag;
  logic [UW-1:0] r1, r2, r3;
  logic [1:0]    quad;
  logic [RW-1:0] rem_q;
  logic [1:0]    quad_q;
  logic          neg_q;

  always_comb begin
    mag = u_i[UW-1] ? UW'(-u_i) : UW'(u_i);
    r1 = mag; r2 = mag; r3 = mag; quad = 2'd0;
    // four compare-subtract steps reduce a magnitude below five quarters
    if (mag >= Quarter) begin r1 = mag - Quarter; quad = 2'd1; end
    r2 = r1;
    if (r1 >= Quarter) begin r2 = r1 - Quarter; quad = 2'd2; end
    r3 = r2;
    if (r2 >= Quarter) begin r3 = r2 - Quarter; quad = 2'd3; end
    if (r3 >= Quarter) begin r3 = r3 - Quarter; quad = 2'd0; end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= RW'(r3);
      quad_q <= quad;
      neg_q  <= u_i[UW-1];
    end
  end

  // stage 1: degrees to radians
  logic [63:0] prod_q;
  logic [1:0]  quad1_q;
  logic        neg1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= 64'(rem_q) * 64'(DegToRadQ36);
      quad1_q <= quad_q;
      neg1_q  <= neg_q;
    end
  end

  logic [63:0] zsum;
  assign zsum = (prod_q + RoundK) >> (ANGLE_FRAC_BITS + 7);

  // cordic rotation stages
  cval_t x_q [CordicSteps+1];
  cval_t y_q [CordicSteps+1];
  cval_t z_q [CordicSteps+1];
  logic [1:0] qd_q [CordicSteps+1];
  logic       ng_q [CordicSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= cval_t'(CordicInvGain);
      y_q[0]  <= '0;
      z_q[0]  <= cval_t'(zsum);
      qd_q[0] <= quad1_q;
      ng_q[0] <= neg1_q;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    cval_t dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_lut(i);
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_lut(i);
        end
        qd_q[i+1] <= qd_q[i];
        ng_q[i+1] <= ng_q[i];
      end
    end
  end

  // quadrant and sign fix-up
  cval_t r;
  always_comb begin
    case (qd_q[CordicSteps])
      2'd0:    r = y_q[CordicSteps];
      2'd1:    r = x_q[CordicSteps];
      2'd2:    r = -y_q[CordicSteps];
      default: r = -x_q[CordicSteps];
    endcase
    sin_o = ng_q[CordicSteps] ? -r : r;
  end

  // z unused beyond the last stage
  logic unused_z;
  assign unused_z = ^z_q[CordicSteps];

  if (LAT == 0) begin : g_never
  end

endmodule

>>> hdl/hvd_sqrt.sv
// pipelined integer floor square root of a 62-bit value, one result bit a stage
// restoring digit-recurrence; uses hvd_pkg
module hvd_sqrt import hvd_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [61:0] v_i,
  output logic [30:0] root_o
);

  logic [61:0] rem_q  [SqrtSteps+1];
  logic [30:0] res_q  [SqrtSteps+1];
  logic [61:0] src_q  [SqrtSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      res_q[0] <= '0;
      src_q[0] <= v_i;
    end
  end

  // each stage brings down two bits and tries the next root bit
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_bit
    logic [63:0] cur, trial;
    assign cur   = {rem_q[i], src_q[i][61:60]};
    assign trial = {31'd0, res_q[i], 2'b01};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= trial) begin
          rem_q[i+1] <= 62'(cur - trial);
          res_q[i+1] <= {res_q[i][29:0], 1'b1};
        end else begin
          rem_q[i+1] <= 62'(cur);
          res_q[i+1] <= {res_q[i][29:0], 1'b0};
        end
        src_q[i+1] <= {src_q[i][59:0], 2'b00};
      end
    end
  end

  assign root_o = res_q[SqrtSteps];

endmodule

>>> hdl/hvd_atan.sv
// pipelined cordic vectoring atan2(e, k) for non-negative q30 inputs
// 30 stages; uses hvd_pkg
module hvd_atan import hvd_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  cval_t e_i,
  input  cval_t k_i,
  output cval_t ang_o
);

  cval_t x_q [CordicSteps+1];
  cval_t y_q [CordicSteps+1];
  cval_t z_q [CordicSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= k_i;
      y_q[0] <= e_i;
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_vec
    cval_t dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][CW-1] && (y_q[i] != '0)) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + atan_lut(i);
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - atan_lut(i);
        end
      end
    end
  end

  assign ang_o = z_q[CordicSteps];

  logic unused_xy;
  assign unused_xy = ^{x_q[CordicSteps], y_q[CordicSteps]};

endmodule

>>> hdl/haversine_distance_degrees_core.sv
// haversine great-circle distance core, top level
// depends on hvd_pkg, hvd_sin, hvd_sqrt and hvd_atan
//
// channel | direction | signals
// request | in        | in_valid_i / in_ready_o, lat_a_i lon_a_i lat_b_i lon_b_i
// result  | out       | out_valid_o / out_ready_i, distance_o
// config  | in        | cfg_we_i, cfg_wdata_i (earth radius)
//
// one request per cycle unless the output stalls; 103 register stages: input stage (1),
// sine cordic (33), product stages (4), square root (32), arctangent cordic (31),
// radius product (1) and output register (1).
// the whole pipeline advances when the output register is free
// or being emptied; a stall freezes every stage so nothing is lost or repeated.
// reset clears valid bits and loads the default radius.
module haversine_distance_degrees_core import hvd_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [29:0] lat_a_i,
  input  logic signed [30:0] lon_a_i,
  input  logic signed [29:0] lat_b_i,
  input  logic signed [30:0] lon_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [32:0]        distance_o
);

  localparam int unsigned UW = ANGLE_FRAC_BITS + 11;
  localparam logic signed [UW-1:0] LatLim = UW'(90) << ANGLE_FRAC_BITS;
  localparam logic signed [UW-1:0] LonLim = UW'(180) << ANGLE_FRAC_BITS;
  localparam int unsigned SinLat  = CordicSteps + 3;
  localparam int unsigned LAT     = 1 + SinLat + 4 + (SqrtSteps + 1) + (CordicSteps + 1) + 1 + 1;
  localparam logic [63:0] One     = 64'd1 << QBits;

  // radius register
  logic [23:0] radius_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) radius_q <= 24'd6371000;
    else if (cfg_we_i) radius_q <= cfg_wdata_i;
  end

  // pipeline advance and valid chain
  logic en;
  logic vld_q [LAT];
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // stage a: saturate and form half-angle arguments
  function automatic logic signed [UW-1:0] sat(input logic signed [UW-1:0] v,
                                               input logic signed [UW-1:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  logic signed [UW-1:0] la, oa, lb, ob;
  logic signed [UW-1:0] u_dlat_q, u_dlon_q, u_c1_q, u_c2_q;
  always_comb begin
    la = sat(UW'(lat_a_i), LatLim);
    oa = sat(UW'(lon_a_i), LonLim);
    lb = sat(UW'(lat_b_i), LatLim);
    ob = sat(UW'(lon_b_i), LonLim);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      u_dlat_q <= lb - la;
      u_dlon_q <= ob - oa;
      u_c1_q   <= (LatLim - la) <<< 1;
      u_c2_q   <= (LatLim - lb) <<< 1;
    end
  end

  // four sine pipelines
  cval_t s1, s2, c1, c2;
  hvd_sin #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .UW(UW)) u_s1 (
    .clk_i, .en_i(en), .u_i(u_dlat_q), .sin_o(s1));
  hvd_sin #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .UW(UW)) u_s2 (
    .clk_i, .en_i(en), .u_i(u_dlon_q), .sin_o(s2));
  hvd_sin #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .UW(UW)) u_c1 (
    .clk_i, .en_i(en), .u_i(u_c1_q), .sin_o(c1));
  hvd_sin #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .UW(UW)) u_c2 (
    .clk_i, .en_i(en), .u_i(u_c2_q), .sin_o(c2));

  // clamp to [0, 1]
  function automatic logic [30:0] clamp01(input cval_t v, input logic take_abs);
    cval_t m;
    m = (take_abs && v[CW-1]) ? -v : v;
    if (m[CW-1]) return '0;
    if (m > cval_t'(One)) return 31'(One);
    return 31'(m);
  endfunction

  // stage p1: clamp, square both sines and form the cosine product
  logic [61:0] s1sq_q, s2sq_q, cc_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1sq_q <= 62'(clamp01(s1, 1'b1)) * 62'(clamp01(s1, 1'b1));
      s2sq_q <= 62'(clamp01(s2, 1'b1)) * 62'(clamp01(s2, 1'b1));
      cc_q   <= 62'(clamp01(c1, 1'b0)) * 62'(clamp01(c2, 1'b0));
    end
  end

  // stage p2: cos product times sin squared of dlon
  logic [61:0] t_q;
  logic [30:0] s1sq2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q     <= 62'(s2sq_q[61:30]) * 62'(cc_q[61:30]);
      s1sq2_q <= 31'(s1sq_q >> 30);
    end
  end

  // stage p3: sum and clamp a
  logic [31:0] a_q;
  logic [32:0] asum;
  assign asum = 33'(s1sq2_q) + 33'(t_q >> 30);
  always_ff @(posedge clk_i) begin
    if (en) a_q <= (asum > 33'(One)) ? 32'(One) : 32'(asum);
  end

  // stage p4: operands for both roots
  logic [61:0] ea_q, ka_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ea_q <= 62'(a_q) << 30;
      ka_q <= 62'(32'(One) - a_q) << 30;
    end
  end

  logic [30:0] e_root, k_root;
  hvd_sqrt u_se (.clk_i, .en_i(en), .v_i(ea_q), .root_o(e_root));
  hvd_sqrt u_sk (.clk_i, .en_i(en), .v_i(ka_q), .root_o(k_root));

  cval_t ang;
  hvd_atan u_at (.clk_i, .en_i(en), .e_i(cval_t'(e_root)), .k_i(cval_t'(k_root)),
                 .ang_o(ang));

  // stage m: radius times angle
  logic [55:0] dprod_q;
  logic [31:0] l;
  assign l = ang[CW-1] ? '0 : 32'(ang);
  always_ff @(posedge clk_i) begin
    if (en) dprod_q <= 56'(radius_q) * 56'(l);
  end

  // stage o: round, saturate, output register
  logic [55:0] dr;
  logic [32:0] dist_q;
  assign dr = (dprod_q + 56'(1 << 20)) >> 21;
  always_ff @(posedge clk_i) begin
    if (en) dist_q <= (dr > 56'(DistMax)) ? DistMax : 33'(dr);
  end
  assign distance_o = dist_q;

endmodule

>>> hdl/hvd_checker.sv
// port-level checker for the haversine distance core, bound to the top level
// depends on haversine_distance_degrees_core
module hvd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [32:0] distance_o
);

  // held result stays stable
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o))
    else $error("stalled result changed");

  // pipeline moves whenever the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  // stall on output blocks input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken during stall");

endmodule

bind haversine_distance_degrees_core hvd_checker u_hvd_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .distance_o);
